// ===== sv/bpa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the page allocator.
package bpa_pkg;

    localparam int DATA_W        = 32;                 // map word and address width
    localparam int MAP_WORDS     = 256;                // words in the page map
    localparam int MAP_IDX_W     = $clog2(MAP_WORDS);  // map word index width
    localparam int BIT_IDX_W     = 5;                  // page index within a map word
    localparam int PAGE_SHIFT    = 12;                 // 4 KiB pages
    localparam int POOL_WORDS_W  = 9;                  // pool_words register width
    localparam int GRP_N         = 16;                 // groups in the search tree
    localparam int GRP_SIZE      = MAP_WORDS / GRP_N;  // map words per group
    localparam int GRP_W         = $clog2(GRP_N);
    localparam int GRP_IDX_W     = $clog2(GRP_SIZE);
    localparam int STATUS_W      = 2;
    localparam int CFG_IDX_W     = 1;
    localparam int FREE_WORD_W   = DATA_W - PAGE_SHIFT - BIT_IDX_W;

    localparam logic [POOL_WORDS_W-1:0] POOL_WORDS_RST = POOL_WORDS_W'(MAP_WORDS);

    // operation codes (s_tuser)
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes (m_tuser)
    localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_WORDS = 1'b1;

    typedef struct packed {
        logic accept;   // latch input word, decode free address
        logic search1;  // register per-group search results
        logic search2;  // register winning map word
        logic read;     // read map word
        logic set_oom;  // result: out of memory
        logic modify;   // update map word, form result
        logic emit;     // move result into output register
    } bpa_cmd_t;

    typedef struct packed {
        logic in_op;      // opcode of the word on the input bus
        logic in_ign;     // free on the input bus is null or out of range
        logic op;         // opcode of the word in flight
        logic found;      // search found a map word with a clear bit
        logic slot_free;  // output register can take a result
    } bpa_stat_t;

endpackage

// ===== sv/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bpa_ctrl.sv =====
// Sequencing state machine of the page allocator.
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SRCH1  = 6'b000010,
        S_SRCH2  = 6'b000100,
        S_READ   = 6'b001000,
        S_MODIFY = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.in_op == OP_ALLOC)
                        state_next = S_SRCH1;
                    else if (stat.in_ign)
                        state_next = S_RESP;
                    else
                        state_next = S_READ;
                end
            end
            S_SRCH1:
            begin
                cmd.search1 = 1'b1;
                state_next  = S_SRCH2;
            end
            S_SRCH2:
            begin
                cmd.search2 = 1'b1;
                state_next  = S_READ;
            end
            S_READ:
            begin
                if (stat.op == OP_ALLOC && !stat.found)
                begin
                    cmd.set_oom = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.read   = 1'b1;
                    state_next = S_MODIFY;
                end
            end
            S_MODIFY:
            begin
                cmd.modify = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== sv/bpa_dp.sv =====
// Datapath: config registers, full/valid vectors, search tree, map RAM and output register.
module bpa_dp
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic [DATA_W-1:0]    s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,
    output logic [STATUS_W-1:0]  m_tuser,
    input  bpa_cmd_t             cmd,
    output bpa_stat_t            stat
);

    logic [DATA_W-1:0]       pool_base_reg;
    logic [POOL_WORDS_W-1:0] pool_words_reg;
    logic [POOL_WORDS_W-1:0] used_words;
    logic [DATA_W-1:0]       base_al;

    logic [MAP_WORDS-1:0]    full_reg;
    logic [MAP_WORDS-1:0]    valid_reg;
    logic [MAP_WORDS-1:0]    avail;

    logic [GRP_N-1:0]        grp_any_reg;
    logic [GRP_IDX_W-1:0]    grp_idx_reg [GRP_N];
    logic [GRP_N-1:0]        grp_any_next;
    logic [GRP_IDX_W-1:0]    grp_idx_next [GRP_N];
    logic [GRP_W-1:0]        win_grp;

    logic                    op_reg;
    logic                    found_reg;
    logic [MAP_IDX_W-1:0]    word_reg;
    logic [BIT_IDX_W-1:0]    bit_reg;

    logic [DATA_W-1:0]       diff;
    logic [FREE_WORD_W-1:0]  free_word;
    logic                    in_ign;

    logic [DATA_W-1:0]       rdata;
    logic [DATA_W-1:0]       cur_word;
    logic [BIT_IDX_W-1:0]    clr_bit;
    logic [DATA_W-1:0]       new_word;
    logic [DATA_W-1:0]       alloc_addr;

    logic [DATA_W-1:0]       res_addr_reg;
    logic [STATUS_W-1:0]     res_status_reg;
    logic                    out_valid_reg;
    logic [DATA_W-1:0]       out_addr_reg;
    logic [STATUS_W-1:0]     out_status_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg  <= '0;
            pool_words_reg <= POOL_WORDS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POOL_BASE:  pool_base_reg  <= cfg_data;
                CFG_POOL_WORDS: pool_words_reg <= cfg_data[POOL_WORDS_W-1:0];
                default: ;
            endcase
        end
    end

    // count saturates at the map size
    assign used_words = (pool_words_reg > POOL_WORDS_RST) ? POOL_WORDS_RST : pool_words_reg;
    assign base_al    = {pool_base_reg[DATA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    // free address decode
    assign diff      = s_tdata - base_al;
    assign free_word = diff[DATA_W-1:PAGE_SHIFT+BIT_IDX_W];
    assign in_ign    = (s_tdata == '0)
                     || (free_word >= FREE_WORD_W'(used_words));

    // search tree, level 1: per group lowest in-use word that is not full
    always_comb
    begin
        for (int w = 0; w < MAP_WORDS; w++)
        begin
            avail[w] = !full_reg[w]
                     && (POOL_WORDS_W'(w) < used_words);
        end
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_any_next[g] = 1'b0;
            grp_idx_next[g] = '0;
            for (int i = GRP_SIZE - 1; i >= 0; i--)
            begin
                if (avail[g*GRP_SIZE + i])
                begin
                    grp_any_next[g] = 1'b1;
                    grp_idx_next[g] = GRP_IDX_W'(i);
                end
            end
        end
    end

    // level 2: lowest group with a hit
    always_comb
    begin
        win_grp = '0;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
                win_grp = GRP_W'(g);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.search1)
        begin
            grp_any_reg <= grp_any_next;
            grp_idx_reg <= grp_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_ALLOC;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
                op_reg <= s_tuser;
            if (cmd.search2)
                found_reg <= |grp_any_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            word_reg <= diff[PAGE_SHIFT+BIT_IDX_W+MAP_IDX_W-1:PAGE_SHIFT+BIT_IDX_W];
            bit_reg  <= diff[PAGE_SHIFT+BIT_IDX_W-1:PAGE_SHIFT];
        end
        else if (cmd.search2)
        begin
            word_reg <= {win_grp, grp_idx_reg[win_grp]};
        end
    end

    bpa_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (cmd.modify),
        .waddr (word_reg),
        .wdata (new_word),
        .re    (cmd.read),
        .raddr (word_reg),
        .rdata (rdata)
    );

    // never-written words read as all free
    assign cur_word = valid_reg[word_reg] ? rdata : '0;

    always_comb
    begin
        clr_bit = '0;
        for (int b = DATA_W - 1; b >= 0; b--)
        begin
            if (!cur_word[b])
                clr_bit = BIT_IDX_W'(b);
        end
    end

    always_comb
    begin
        if (op_reg == OP_ALLOC)
            new_word = cur_word | (DATA_W'(1) << clr_bit);
        else
            new_word = cur_word & ~(DATA_W'(1) << bit_reg);
    end

    assign alloc_addr = base_al
                      + DATA_W'({word_reg, clr_bit, {PAGE_SHIFT{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg  <= '0;
            valid_reg <= '0;
        end
        else if (cmd.modify)
        begin
            full_reg[word_reg]  <= (new_word == {DATA_W{1'b1}});
            valid_reg[word_reg] <= 1'b1;
        end
    end

    // result holding register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_IGNORED;
        end
        else if (cmd.set_oom)
        begin
            res_addr_reg   <= '0;
            res_status_reg <= ST_OOM;
        end
        else if (cmd.modify)
        begin
            if (op_reg == OP_ALLOC)
            begin
                res_addr_reg   <= alloc_addr;
                res_status_reg <= ST_ALLOC;
            end
            else
            begin
                res_addr_reg   <= '0;
                res_status_reg <= ST_FREED;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_addr_reg;
    assign m_tuser  = out_status_reg;

    assign stat.in_op     = s_tuser;
    assign stat.in_ign    = in_ign;
    assign stat.op        = op_reg;
    assign stat.found     = found_reg;
    assign stat.slot_free = !out_valid_reg || m_tready;

endmodule

// ===== sv/bitmap_page_allocator_top.sv =====
// Top level of the bitmap page allocator: controller plus datapath.
//
//  channel | direction | tdata               | tuser          | notes
//  s_*     | in        | [31:0] free_address | [0] opcode     | 0 alloc, 1 free
//  m_*     | out       | [31:0] page_address | [1:0] status   | one word per input word
//  cfg_*   | in        | [31:0] cfg_data     | -              | idx 0 pool_base, 1 pool_words
//
// One request in flight. Allocate: two-level registered search of the full-word vector,
// then map RAM read-modify-write. Out of memory skips the RAM, a free skips the search,
// a null or out-of-range free skips both; next accept in the cycle after the emit.
// Reset clears the full and valid vectors at once; no clearing pass is needed.
// A result waiting in the output register does not block the next accept; the following
// result waits in the response state until the output register drains.
module bitmap_page_allocator_top
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] free_address
    input  logic                 s_tuser,   // [0] opcode
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [31:0] page_address
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    // sequencer: accept, search, RAM read, modify, respond
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // map storage, search tree, address math and output word
    bpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== sv/bpa_checker.sv =====
// Port-level checks of the page allocator, bound to the top level.
module bpa_checker
    import bpa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [DATA_W-1:0]    m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    // failed allocations and all frees return a null address
    a_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_OOM || m_tuser == ST_FREED || m_tuser == ST_IGNORED))
        |-> (m_tdata == '0))
        else $error("non-allocate result with nonzero address");

    // allocated addresses are page aligned
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_ALLOC) |-> (m_tdata[PAGE_SHIFT-1:0] == '0))
        else $error("allocated address not page aligned");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind bitmap_page_allocator_top bpa_checker u_bpa_checker (.*);

// ===== sim/page_grant_checker.sv =====
// Scoreboard for the page allocator: mirrors the page map, predicts each reply, checks it.
module page_grant_checker
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [31:0] free_address
    input  logic                 s_tuser,   // [0] opcode
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [DATA_W-1:0]    m_tdata,   // [31:0] page_address
    input  logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output int                   error_count,
    output int                   replies_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0]   page_address;
        logic [STATUS_W-1:0] status;
    } reply_t;

    logic [DATA_W-1:0]       page_map [MAP_WORDS];
    logic [DATA_W-1:0]       base_reg;
    logic [POOL_WORDS_W-1:0] words_reg;
    reply_t                  owed_replies [$];
    int                      errs;

    // Apply one request to the mirrored map and return the reply it must produce.
    function automatic reply_t serve_request(input logic op, input logic [DATA_W-1:0] addr);
        reply_t            r;
        logic [DATA_W-1:0] base_al;
        logic [DATA_W-1:0] page;
        int                used;
        int                w;
        int                b;
        logic              hit;
        base_al = {base_reg[DATA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
        used = (words_reg > MAP_WORDS) ? MAP_WORDS : int'(words_reg);
        r.page_address = '0;
        r.status = ST_IGNORED;
        if (op == OP_ALLOC)
        begin
            r.status = ST_OOM;
            hit = 1'b0;
            for (w = 0; w < used && !hit; w++)
            begin
                if (page_map[w] != '1)
                begin
                    b = 0;
                    while (page_map[w][b])
                        b++;
                    page_map[w][b] = 1'b1;
                    r.page_address = base_al + (DATA_W'(w * 32 + b) << PAGE_SHIFT);
                    r.status = ST_ALLOC;
                    hit = 1'b1;
                end
            end
        end
        else if (addr != '0)
        begin
            // offset wraps mod 2^32, so addresses just below the base land far out of range
            page = (addr - base_al) >> PAGE_SHIFT;
            if ((page >> BIT_IDX_W) < DATA_W'(used))
            begin
                page_map[page >> BIT_IDX_W][page[BIT_IDX_W-1:0]] = 1'b0;
                r.status = ST_FREED;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAP_WORDS; i++)
                page_map[i] = '0;
            base_reg = '0;
            words_reg = POOL_WORDS_RST;
            owed_replies.delete();
            errs = 0;
            error_count <= 0;
            replies_owed <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_POOL_BASE:  base_reg = cfg_data;
                    CFG_POOL_WORDS: words_reg = cfg_data[POOL_WORDS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                owed_replies.push_back(serve_request(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (owed_replies.size() == 0)
                begin
                    $error("reply with none owed: page_address %h status %0d", m_tdata, m_tuser);
                    errs++;
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (m_tdata !== want.page_address)
                    begin
                        $error("page_address: expected %h, got %h", want.page_address, m_tdata);
                        errs++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errs++;
                    end
                end
            end
            error_count <= errs;
            replies_owed <= owed_replies.size();
        end
    end

endmodule

// ===== sim/bitmap_page_allocator_top_test.sv =====
// Stimulus and verdict for the bitmap page allocator: directed cases, then random pool phases.
module bitmap_page_allocator_top_test;
    import bpa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1250;    // random request words to send
    localparam int CYCLE_LIMIT  = 400000;  // watchdog limit
    localparam int STALL_AT     = 300;     // sent words before the long output stall
    localparam int STALL_LEN    = 400;     // cycles the output holds off
    localparam int DRAIN_WAIT   = 8;       // slack after the last owed reply drains

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata;     // [31:0] free_address
    logic                 s_tuser;     // [0] opcode
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;     // [31:0] page_address
    logic [STATUS_W-1:0]  m_tuser;     // [1:0] status

    int                      error_count;
    int                      replies_owed;
    int                      sent_words = 0;
    int                      cycle_count = 0;
    bit                      stall_done = 1'b0;
    logic [DATA_W-1:0]       cur_base = '0;        // stimulus-side copy of pool_base
    logic [POOL_WORDS_W-1:0] cur_words = POOL_WORDS_RST;

    bitmap_page_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    page_grant_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .error_count  (error_count),
        .replies_owed (replies_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both sides run back to back through this window of the run.
    function automatic bit steady_window();
        return sent_words >= 700 && sent_words < 900;
    endfunction

    // Result side: random back-pressure, plus one long hold-off once the stream is busy
    // so the single in-flight slot and the output register both back up into s_tready.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!stall_done && sent_words >= STALL_AT)
            begin
                stall_done = 1'b1;
                m_tready <= 1'b0;
                repeat (STALL_LEN) @(posedge clk);
            end
            m_tready <= steady_window() || ($urandom_range(99) >= 21);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one request word, with a random gap first, and hold it until accepted.
    task automatic send_word(input logic op, input logic [DATA_W-1:0] addr);
        while (!steady_window() && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_words++;
    endtask

    // Drop valid and wait for every owed reply, then let the pipe go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (replies_owed != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Program both pool registers in either order; upper pool_words data bits are junk.
    task automatic program_pool(input logic [DATA_W-1:0] base, input logic [DATA_W-1:0] words_raw);
        if ($urandom_range(1))
        begin
            write_reg(CFG_POOL_BASE, base);
            write_reg(CFG_POOL_WORDS, words_raw);
        end
        else
        begin
            write_reg(CFG_POOL_WORDS, words_raw);
            write_reg(CFG_POOL_BASE, base);
        end
        cfg_we <= 1'b0;
        cur_base = base;
        cur_words = words_raw[POOL_WORDS_W-1:0];
    endtask

    // Mostly pages inside (or just past) the current pool, with random low bits;
    // some null and fully random addresses as noise.
    function automatic logic [DATA_W-1:0] pick_free_address();
        int          roll;
        int          span;
        logic [31:0] page;
        roll = $urandom_range(99);
        span = ((cur_words > MAP_WORDS) ? MAP_WORDS : int'(cur_words)) * 32;
        if (roll < 8)
            return $urandom;
        if (roll < 12)
            return '0;
        page = $urandom_range(1) ? $urandom_range(0, 63) : $urandom_range(0, span + 7);
        return {cur_base[DATA_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}}
               + (page << PAGE_SHIFT) + $urandom_range(0, 4095);
    endfunction

    initial
    begin
        int          rand_sent;
        int          phase_len;
        int          alloc_pct;
        int          pick;
        logic [31:0] new_base;
        logic [31:0] new_words;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_POOL_BASE;
        cfg_data <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= OP_ALLOC;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset pool: base 0, all 256 words. First grant is address 0 itself.
        send_word(OP_ALLOC, 32'hFFFF_FFFF);
        send_word(OP_ALLOC, 32'h0000_0000);
        send_word(OP_ALLOC, 32'h1234_5678);
        send_word(OP_FREE, 32'h0000_0000);        // null free
        send_word(OP_FREE, 32'h0000_1FFF);        // low bits ignored
        send_word(OP_FREE, 32'h0000_1000);        // double free
        send_word(OP_ALLOC, 32'h0000_0000);       // reuses the lowest hole
        send_word(OP_FREE, 32'h0020_0000);        // page never taken
        send_word(OP_FREE, 32'h01FF_F000);        // last page of the map
        send_word(OP_FREE, 32'h0200_0000);        // one word past the map
        send_word(OP_FREE, 32'hFFFF_FFFF);
        settle();

        // Empty pool: allocs run out, every free is out of range.
        program_pool(32'h0000_0000, 32'h0000_0000);
        send_word(OP_ALLOC, 32'h0000_0000);
        send_word(OP_FREE, 32'h0000_1000);
        settle();

        // Oversized pool_words saturates; top-of-memory base wraps the address.
        program_pool(32'hFFFF_F5A5, 32'hFFFF_FFFF);
        send_word(OP_ALLOC, 32'h0000_0000);       // page 3 wraps to 0x2000
        send_word(OP_FREE, 32'h0000_1000);        // below base, wraps into the pool
        send_word(OP_FREE, 32'hFFFF_E000);        // just below base, out of range
        send_word(OP_ALLOC, 32'h0000_0000);
        settle();

        // Random phases: new pool setting each time, mostly small pools so runs
        // reach out-of-memory; the map carries over, so shrinking leaves stale bits.
        rand_sent = 0;
        while (rand_sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(9);
            case (pick)
                0:       new_words = 32'd0;
                6:       new_words = 32'd256;
                7:       new_words = $urandom_range(257, 511);
                8:       new_words = $urandom_range(4, 16);
                9:       new_words = 32'd511;
                default: new_words = $urandom_range(1, 3);
            endcase
            if ($urandom_range(3) == 0)
                new_words = {$urandom} & 32'hFFFF_FE00 | new_words;
            pick = $urandom_range(7);
            case (pick)
                0:       new_base = 32'h0000_0000;
                1:       new_base = 32'hFFFF_FFFF;
                2:       new_base = cur_base;
                default: new_base = $urandom;
            endcase
            program_pool(new_base, new_words);

            phase_len = $urandom_range(40, 120);
            alloc_pct = $urandom_range(30, 85);
            repeat (phase_len)
            begin
                if ($urandom_range(99) < alloc_pct)
                    send_word(OP_ALLOC, $urandom);   // data is don't-care on alloc
                else
                    send_word(OP_FREE, pick_free_address());
                rand_sent++;
            end
            settle();
        end

        if (error_count == 0 && replies_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
